// ===== hdl/fenbb_pkg.sv =====
// fenbb_pkg: character codes, flag positions, field numbers, board and counter
// limits, result width and piece slots shared by the fen_to_bitboard_parser design
// no dependencies

package fenbb_pkg;

    // character codes
    localparam logic [7:0] ASCII_TAB   = 8'h09;
    localparam logic [7:0] ASCII_CR    = 8'h0D;
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_SLASH = 8'h2F;
    localparam logic [7:0] ASCII_DASH  = 8'h2D;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_ONE   = 8'h31;
    localparam logic [7:0] ASCII_EIGHT = 8'h38;
    localparam logic [7:0] ASCII_NINE  = 8'h39;
    localparam logic [7:0] ASCII_UC_A  = 8'h41;
    localparam logic [7:0] ASCII_UC_Z  = 8'h5A;
    localparam logic [7:0] ASCII_LC_A  = 8'h61;
    localparam logic [7:0] ASCII_LC_H  = 8'h68;
    localparam logic [7:0] ASCII_LC_Z  = 8'h7A;
    localparam logic [7:0] ASCII_UC_K  = 8'h4B;
    localparam logic [7:0] ASCII_UC_Q  = 8'h51;
    localparam logic [7:0] ASCII_LC_K  = 8'h6B;
    localparam logic [7:0] ASCII_LC_Q  = 8'h71;
    localparam logic [7:0] ASCII_LC_R  = 8'h72;
    localparam logic [7:0] ASCII_LC_B  = 8'h62;
    localparam logic [7:0] ASCII_LC_N  = 8'h6E;
    localparam logic [7:0] ASCII_LC_P  = 8'h70;
    localparam logic [7:0] ASCII_LC_W  = 8'h77;
    localparam logic [7:0] CASE_BIT    = 8'h20;

    // status flag bit positions
    localparam int FLAG_ERR = 6;
    localparam int FLAG_EPV = 5;
    localparam int FLAG_WTM = 4;
    localparam int FLAG_WK  = 3;
    localparam int FLAG_WQ  = 2;
    localparam int FLAG_BK  = 1;
    localparam int FLAG_BQ  = 0;

    // field numbers of the string
    localparam logic [2:0] FIELD_PLACE    = 3'd0;
    localparam logic [2:0] FIELD_SIDE     = 3'd1;
    localparam logic [2:0] FIELD_CASTLE   = 3'd2;
    localparam logic [2:0] FIELD_EP       = 3'd3;
    localparam logic [2:0] FIELD_HALFMOVE = 3'd4;
    localparam logic [2:0] FIELD_FULLMOVE = 3'd5;
    localparam logic [2:0] FIELD_LAST     = 3'd7;

    // board geometry and counter limits
    localparam logic [6:0]  SQ_END   = 7'd64;
    localparam logic [13:0] ACC_MAX  = 14'd16383;
    localparam int          NUM_PIECES = 6;

    // result transaction width
    localparam int OUT_TDATA_W = 560;

    typedef enum logic [2:0] {
        SLOT_KING   = 3'd0,
        SLOT_QUEEN  = 3'd1,
        SLOT_ROOK   = 3'd2,
        SLOT_BISHOP = 3'd3,
        SLOT_KNIGHT = 3'd4,
        SLOT_PAWN   = 3'd5
    } t_piece_slot;

endpackage

// ===== hdl/fen_to_bitboard_parser.sv =====
// fen_to_bitboard_parser: parses a FEN string, one character per transaction,
// into piece and colour bitboards, status flags and move counters
// depends on fenbb_pkg

// One character is taken per clock cycle, save for the stall below, with no gaps between
// strings. The whole decode of a character (field tracking, square bit set,
// times-ten accumulate) is one short combinational pass into the state
// registers, so the rate is one character per cycle; the result for a string
// leaves the output register on the cycle after its last character is taken.
// The input side stalls only while a finished result sits unaccepted in that
// register. Characters past MAX_CHARS are ignored but the last mark still
// produces a result. Bit 63 of a board is a8 and bit 0 is h1.
module fen_to_bitboard_parser #(
    parameter int MAX_CHARS  = 256,
    parameter int MAX_DIGITS = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [7:0]                         i_s_tdata,  // character
    input  logic                               i_s_tlast,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // king, queen, rook, bishop, knight, pawn, white, black boards (64 each),
    // status_flags (7), en_passant_square (6), halfmove_clock (14),
    // fullmove_number (14), zero fill (7)
    output logic [fenbb_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);
    import fenbb_pkg::*;

    localparam int CC_W = $clog2(MAX_CHARS + 1);
    localparam int DC_W = (MAX_DIGITS < 3) ? 2 : $clog2(MAX_DIGITS + 1);
    localparam int PROD_W = 18;

    // parser state
    logic [63:0]     r_piece [NUM_PIECES];
    logic [63:0]     n_piece [NUM_PIECES];
    logic [63:0]     r_white, n_white;
    logic [63:0]     r_black, n_black;
    logic [6:0]      r_sq, n_sq;
    logic [2:0]      r_field, n_field;
    logic [CC_W-1:0] r_char_cnt, n_char_cnt;
    logic [6:0]      r_flags, n_flags;
    logic [5:0]      r_ep, n_ep;
    logic [13:0]     r_acc [2];
    logic [13:0]     n_acc [2];
    logic [DC_W-1:0] r_digits, n_digits;

    // output register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic s_acc;
    logic m_acc;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign m_acc      = r_out_valid && i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // character decode and next state
    always_comb begin
        logic [7:0]        c;
        logic              is_ws;
        logic              is_letter;
        logic              is_digit;
        logic [3:0]        dval;
        logic              slot_ok;
        t_piece_slot       slot;
        logic [63:0]       sq_bit;
        logic [6:0]        sq_sum;
        logic              acc_sel;
        logic [PROD_W-1:0] acc_wide;
        logic [PROD_W-1:0] prod;

        c         = i_s_tdata;
        is_ws     = (c == ASCII_SPACE) || (c inside {[ASCII_TAB:ASCII_CR]});
        is_letter = (c inside {[ASCII_LC_A:ASCII_LC_Z]}) ||
                    (c inside {[ASCII_UC_A:ASCII_UC_Z]});
        is_digit  = c inside {[ASCII_ZERO:ASCII_NINE]};
        dval      = c[3:0];

        slot_ok = 1'b1;
        slot    = SLOT_KING;
        case (c | CASE_BIT)
            ASCII_LC_K: slot = SLOT_KING;
            ASCII_LC_Q: slot = SLOT_QUEEN;
            ASCII_LC_R: slot = SLOT_ROOK;
            ASCII_LC_B: slot = SLOT_BISHOP;
            ASCII_LC_N: slot = SLOT_KNIGHT;
            ASCII_LC_P: slot = SLOT_PAWN;
            default:    slot_ok = 1'b0;
        endcase

        sq_bit = (r_sq < SQ_END) ? (64'd1 << (6'd63 - r_sq[5:0])) : 64'd0;
        sq_sum = r_sq + 7'(dval);

        acc_sel  = r_field[0];
        acc_wide = PROD_W'(r_acc[acc_sel]);
        prod     = (acc_wide << 3) + (acc_wide << 1) + PROD_W'(dval);

        n_piece    = r_piece;
        n_white    = r_white;
        n_black    = r_black;
        n_sq       = r_sq;
        n_field    = r_field;
        n_char_cnt = r_char_cnt;
        n_flags    = r_flags;
        n_ep       = r_ep;
        n_acc      = r_acc;
        n_digits   = r_digits;

        if (r_char_cnt < CC_W'(MAX_CHARS)) begin
            n_char_cnt = r_char_cnt + 1'b1;
            if (is_ws) begin
                // whitespace moves to the next field, saturating
                if (r_field != FIELD_LAST) begin
                    n_field = r_field + 1'b1;
                end
                n_digits = '0;
            end else begin
                case (r_field)
                    FIELD_PLACE: begin
                        if (is_letter) begin
                            if (!slot_ok) begin
                                n_flags[FLAG_ERR] = 1'b1;
                            end else begin
                                n_piece[slot] = r_piece[slot] | sq_bit;
                                if (c >= ASCII_LC_A) begin
                                    n_black = r_black | sq_bit;
                                end else begin
                                    n_white = r_white | sq_bit;
                                end
                            end
                            n_sq = (r_sq < SQ_END) ? r_sq + 7'd1 : SQ_END;
                        end else if (is_digit) begin
                            n_sq = (sq_sum > SQ_END) ? SQ_END : sq_sum;
                        end
                    end
                    FIELD_SIDE: begin
                        n_flags[FLAG_WTM] = (c == ASCII_LC_W);
                    end
                    FIELD_CASTLE: begin
                        if (c == ASCII_UC_K) begin
                            n_flags[FLAG_WK] = 1'b1;
                        end else if (c == ASCII_UC_Q) begin
                            n_flags[FLAG_WQ] = 1'b1;
                        end else if (c == ASCII_LC_K) begin
                            n_flags[FLAG_BK] = 1'b1;
                        end else if (c == ASCII_LC_Q) begin
                            n_flags[FLAG_BQ] = 1'b1;
                        end
                    end
                    FIELD_EP: begin
                        // file first, then rank; a dash is skipped
                        if (c != ASCII_DASH) begin
                            if (r_digits == DC_W'(0)) begin
                                if (c inside {[ASCII_LC_A:ASCII_LC_H]}) begin
                                    n_ep = 6'(8'd7 - (c - ASCII_LC_A));
                                end else begin
                                    n_flags[FLAG_ERR] = 1'b1;
                                end
                                n_digits = DC_W'(1);
                            end else if (r_digits == DC_W'(1)) begin
                                if ((c inside {[ASCII_ONE:ASCII_EIGHT]}) &&
                                    (r_ep < 6'd8) && !r_flags[FLAG_ERR]) begin
                                    n_ep = {3'(c - ASCII_ONE), r_ep[2:0]};
                                    n_flags[FLAG_EPV] = 1'b1;
                                end else begin
                                    n_flags[FLAG_ERR] = 1'b1;
                                end
                                n_digits = DC_W'(2);
                            end
                        end
                    end
                    FIELD_HALFMOVE, FIELD_FULLMOVE: begin
                        // decimal accumulate, limited digit count
                        if (is_digit) begin
                            if (r_digits >= DC_W'(MAX_DIGITS)) begin
                                n_flags[FLAG_ERR] = 1'b1;
                            end else begin
                                n_digits = r_digits + 1'b1;
                                n_acc[acc_sel] = (prod > PROD_W'(ACC_MAX)) ?
                                                 ACC_MAX : prod[13:0];
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // state registers, cleared after each string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (s_acc && i_s_tlast)) begin
            r_piece    <= '{default: '0};
            r_white    <= '0;
            r_black    <= '0;
            r_sq       <= '0;
            r_field    <= '0;
            r_char_cnt <= '0;
            r_flags    <= '0;
            r_ep       <= '0;
            r_acc      <= '{default: '0};
            r_digits   <= '0;
        end else if (s_acc) begin
            r_piece    <= n_piece;
            r_white    <= n_white;
            r_black    <= n_black;
            r_sq       <= n_sq;
            r_field    <= n_field;
            r_char_cnt <= n_char_cnt;
            r_flags    <= n_flags;
            r_ep       <= n_ep;
            r_acc      <= n_acc;
            r_digits   <= n_digits;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_acc && i_s_tlast) begin
            r_out_valid <= 1'b1;
        end else if (m_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (s_acc && i_s_tlast) begin
            r_out_data <= {7'd0, n_acc[1], n_acc[0],
                           (n_flags[FLAG_EPV] ? n_ep : 6'd0), n_flags,
                           n_black, n_white,
                           n_piece[SLOT_PAWN], n_piece[SLOT_KNIGHT],
                           n_piece[SLOT_BISHOP], n_piece[SLOT_ROOK],
                           n_piece[SLOT_QUEEN], n_piece[SLOT_KING]};
        end
    end

`ifndef NO_ASSERTIONS
    a_sq_bounded : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq <= SQ_END)
        else $error("square counter past end of board");

    a_colour_disjoint : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_white & r_black) == 64'd0)
        else $error("square marked both colours");

    a_colour_matches_pieces : assert property (@(posedge i_clk)
        disable iff (!i_rst_n)
        (r_white | r_black) == (r_piece[SLOT_KING] | r_piece[SLOT_QUEEN] |
                                r_piece[SLOT_ROOK] | r_piece[SLOT_BISHOP] |
                                r_piece[SLOT_KNIGHT] | r_piece[SLOT_PAWN]))
        else $error("colour boards disagree with piece boards");

    a_clear_after_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_tlast) |=>
            (r_char_cnt == '0 && r_field == FIELD_PLACE && r_sq == '0))
        else $error("state not cleared after last character");

    a_result_from_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s_acc && i_s_tlast))
        else $error("result raised without a last character");
`endif

endmodule
